// File: sv/sfn_pkg.sv
// Shared constants for the surface normal pipeline.
package sfn_pkg;

  localparam int POINT_BITS            = 60;
  localparam int PRESENT_BITS          = 4;
  localparam int OUT_BITS              = 16;
  localparam int COORD_BITS_DEF        = 20;
  localparam int NORMAL_FRAC_BITS_DEF  = 15;
  // Fraction bits of the internal unit vectors.
  localparam int IFRAC                 = 28;
  localparam int NB_COUNT              = 4;
  // Operand pairs of the four cross products: right x up, right x down,
  // left x up, left x down.
  localparam int PAIR_A [NB_COUNT] = '{0, 0, 2, 2};
  localparam int PAIR_B [NB_COUNT] = '{1, 3, 1, 3};

endpackage

// File: sv/sfn_unit.sv
// Pipelined vector normaliser: squares, bit-per-stage square root, bit-per-stage division.
module sfn_unit #(
  parameter int LANES = 4,
  parameter int VW    = 21,
  parameter int SHIFT = 28,
  parameter int PW    = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    src_valid,
  input  logic signed [VW-1:0]    src_vec [LANES][3],
  input  logic [PW-1:0]           src_tag,
  output logic                    res_valid,
  output logic signed [SHIFT+1:0] res_vec [LANES][3],
  output logic [PW-1:0]           res_tag
);

  localparam int MW = 2 * VW;
  localparam int K  = VW;
  localparam int RW = VW + 1;
  localparam int QW = SHIFT + 2;
  localparam int NW = VW + SHIFT + 3;
  localparam int T  = K + QW + 4;

  logic              vld  [T];
  logic [PW-1:0]     tag  [T];
  logic [VW-1:0]     mag  [T][LANES][3];
  logic              sgn  [T][LANES][3];
  logic [VW-1:0]     src_mag [LANES][3];
  logic [MW-1:0]     sq   [LANES][3];
  logic [MW-1:0]     m2   [LANES];
  logic [MW-1:0]     srem  [K][LANES];
  logic [MW-1:0]     sroot [K][LANES];
  logic [NW-1:0]     drem [QW+1][LANES][3];
  logic [NW-1:0]     dden [QW+1][LANES];
  logic [QW-1:0]     dq   [QW+1][LANES][3];
  logic              zro  [QW+1][LANES];
  logic signed [SHIFT+1:0] res [LANES][3];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < 3; k++) begin
        src_mag[l][k] = src_vec[l][k][VW-1] ? VW'(-src_vec[l][k]) : VW'(src_vec[l][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < T; t++) begin
        vld[t] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= src_valid;
      for (int t = 1; t < T; t++) begin
        vld[t] <= vld[t-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= src_tag;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < 3; k++) begin
          mag[0][l][k] <= src_mag[l][k];
          sgn[0][l][k] <= src_vec[l][k][VW-1];
          sq[l][k]     <= MW'(src_mag[l][k]) * MW'(src_mag[l][k]);
        end
        m2[l] <= sq[l][0] + sq[l][1] + sq[l][2];
      end
      for (int t = 1; t < T; t++) begin
        tag[t] <= tag[t-1];
        mag[t] <= mag[t-1];
        sgn[t] <= sgn[t-1];
      end
    end
  end

  // Square root, one result bit per stage.
  for (genvar s = 0; s < K; s++) begin : g_sqrt
    localparam logic [MW-1:0] BITV = {{(MW-1){1'b0}}, 1'b1} << (2 * (K - 1 - s));
    logic [MW-1:0] rem_p  [LANES];
    logic [MW-1:0] root_p [LANES];
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l]  = m2[l];
          root_p[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_p[l]  = srem[s-1][l];
          root_p[l] = sroot[s-1][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (rem_p[l] >= root_p[l] + BITV) begin
            srem[s][l]  <= rem_p[l] - (root_p[l] + BITV);
            sroot[s][l] <= (root_p[l] >> 1) + BITV;
          end else begin
            srem[s][l]  <= rem_p[l];
            sroot[s][l] <= root_p[l] >> 1;
          end
        end
      end
    end
  end

  // Division set-up: round(m / n) is floor((2m + n) / 2n).
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        dden[0][l] <= NW'(sroot[K-1][l][RW-1:0]) << 1;
        zro[0][l]  <= (sroot[K-1][l] == '0);
        for (int k = 0; k < 3; k++) begin
          drem[0][l][k] <= (NW'(mag[K+1][l][k]) << (SHIFT + 1))
                           + NW'(sroot[K-1][l][RW-1:0]);
          dq[0][l][k]   <= '0;
        end
      end
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int SH = QW - j;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          dden[j][l] <= dden[j-1][l];
          zro[j][l]  <= zro[j-1][l];
          for (int k = 0; k < 3; k++) begin
            if (drem[j-1][l][k] >= (dden[j-1][l] << SH)) begin
              drem[j][l][k] <= drem[j-1][l][k] - (dden[j-1][l] << SH);
              dq[j][l][k]   <= dq[j-1][l][k] | (QW'(1) << SH);
            end else begin
              drem[j][l][k] <= drem[j-1][l][k];
              dq[j][l][k]   <= dq[j-1][l][k];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < 3; k++) begin
          if (zro[QW][l]) begin
            res[l][k] <= '0;
          end else if (sgn[K+QW+2][l][k]) begin
            res[l][k] <= -$signed(dq[QW][l][k]);
          end else begin
            res[l][k] <= $signed(dq[QW][l][k]);
          end
        end
      end
    end
  end

  assign res_valid = vld[T-1];
  assign res_tag   = tag[T-1];
  assign res_vec   = res;

endmodule

// File: sv/surface_normal_from_neighbours_top.sv
// Top level of the range-image surface normal pipeline.
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    centre_point, right_point, up_point,
//                                        left_point, down_point, neighbour_present
//   result    result_valid / result_stall normal_x, normal_y, normal_z, normal_valid
//
// One item enters in every cycle unless the result channel stalls, and each item gives exactly one result.
// Most of the latency lies in the three normaliser pipelines, whose square
// root and division each retire one bit per stage.
// Reset is synchronous and clears only the valid bits of the pipeline.
// A stalled result with valid high freezes the whole pipeline, so the item
// channel stalls in the same cycle and nothing is lost or repeated.
module surface_normal_from_neighbours_top #(
  parameter int COORD_BITS       = sfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = sfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [sfn_pkg::POINT_BITS-1:0]       centre_point,
  input  logic [sfn_pkg::POINT_BITS-1:0]       right_point,
  input  logic [sfn_pkg::POINT_BITS-1:0]       up_point,
  input  logic [sfn_pkg::POINT_BITS-1:0]       left_point,
  input  logic [sfn_pkg::POINT_BITS-1:0]       down_point,
  input  logic [sfn_pkg::PRESENT_BITS-1:0]     neighbour_present,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [sfn_pkg::OUT_BITS-1:0]  normal_x,
  output logic signed [sfn_pkg::OUT_BITS-1:0]  normal_y,
  output logic signed [sfn_pkg::OUT_BITS-1:0]  normal_z,
  output logic                                 normal_valid
);

  localparam int CB    = COORD_BITS;
  localparam int CP    = 3 * CB;
  localparam int EW    = CP + sfn_pkg::POINT_BITS;
  localparam int VW1   = CB + 1;
  localparam int UW    = sfn_pkg::IFRAC + 2;
  localparam int PRW   = 2 * UW;
  localparam int DFW   = PRW + 1;
  localparam int CW    = sfn_pkg::IFRAC + 3;
  localparam int DOTW  = UW + CB;
  localparam int DSW   = DOTW + 2;
  localparam int SUMW  = sfn_pkg::IFRAC + 4;
  localparam int FW    = NORMAL_FRAC_BITS + 2;
  localparam int NB    = sfn_pkg::NB_COUNT;
  localparam logic signed [FW-1:0] LIM = FW'((64'd1 << NORMAL_FRAC_BITS) - 64'd1);
  localparam logic [DFW-1:0] HALF = DFW'(1) << (sfn_pkg::IFRAC - 1);

  logic en;

  // The whole pipeline moves unless a finished result is held back.
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // Input stage: unpack the points and form the neighbour offsets.
  logic [EW-1:0]            pext [NB+1];
  logic signed [CB-1:0]     cc   [3];
  logic signed [VW1-1:0]    ca   [3];
  logic signed [VW1-1:0]    na   [3];
  logic signed [VW1-1:0]    d_comb [NB][3];
  logic                     d0_valid;
  logic signed [VW1-1:0]    d0_vec [NB][3];
  logic [CP-1:0]            d0_ctr;

  always_comb begin
    pext[0] = EW'(centre_point);
    pext[1] = EW'(right_point);
    pext[2] = EW'(up_point);
    pext[3] = EW'(left_point);
    pext[4] = EW'(down_point);
    for (int k = 0; k < 3; k++) begin
      cc[k] = $signed(pext[0][k*CB +: CB]);
      ca[k] = cc[k];
    end
    for (int j = 0; j < NB; j++) begin
      for (int k = 0; k < 3; k++) begin
        na[k] = $signed(pext[j+1][k*CB +: CB]);
        // An absent neighbour contributes a zero vector, which the
        // normaliser passes through as zero; so does a coincident one.
        d_comb[j][k] = neighbour_present[j] ? (na[k] - ca[k]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_valid <= 1'b0;
    end else if (en) begin
      d0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_vec <= d_comb;
      d0_ctr <= pext[0][CP-1:0];
    end
  end

  // Unit vectors towards the four neighbours.
  logic                   u1_valid;
  logic signed [UW-1:0]   u1_vec [NB][3];
  logic [CP-1:0]          u1_ctr;

  sfn_unit #(
    .LANES(NB), .VW(VW1), .SHIFT(sfn_pkg::IFRAC), .PW(CP)
  ) u_nb_unit (
    .clk(clk), .rst(rst), .en(en),
    .src_valid(d0_valid), .src_vec(d0_vec), .src_tag(d0_ctr),
    .res_valid(u1_valid), .res_vec(u1_vec), .res_tag(u1_ctr)
  );

  // Cross products: partial products first, then difference and rounding.
  logic                   x0_valid;
  logic signed [PRW-1:0]  x0_prod [NB][6];
  logic [CP-1:0]          x0_ctr;
  logic signed [PRW-1:0]  av [NB][3];
  logic signed [PRW-1:0]  bv [NB][3];

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      for (int k = 0; k < 3; k++) begin
        av[j][k] = u1_vec[sfn_pkg::PAIR_A[j]][k];
        bv[j][k] = u1_vec[sfn_pkg::PAIR_B[j]][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x0_valid <= 1'b0;
    end else if (en) begin
      x0_valid <= u1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_ctr <= u1_ctr;
      for (int j = 0; j < NB; j++) begin
        x0_prod[j][0] <= av[j][1] * bv[j][2];
        x0_prod[j][1] <= av[j][2] * bv[j][1];
        x0_prod[j][2] <= av[j][2] * bv[j][0];
        x0_prod[j][3] <= av[j][0] * bv[j][2];
        x0_prod[j][4] <= av[j][0] * bv[j][1];
        x0_prod[j][5] <= av[j][1] * bv[j][0];
      end
    end
  end

  logic                   x1_valid;
  logic signed [CW-1:0]   x1_vec [NB][3];
  logic [CP-1:0]          x1_ctr;
  logic signed [DFW-1:0]  xdif [NB][3];
  logic [DFW-1:0]         xmag [NB][3];
  logic [DFW-1:0]         xrnd [NB][3];
  logic signed [DFW-1:0]  pa;
  logic signed [DFW-1:0]  pb;

  // Each component is rounded to the internal fraction, half away from zero.
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      for (int k = 0; k < 3; k++) begin
        pa = x0_prod[j][2*k];
        pb = x0_prod[j][2*k+1];
        xdif[j][k] = pa - pb;
        xmag[j][k] = xdif[j][k][DFW-1] ? DFW'(-xdif[j][k]) : DFW'(xdif[j][k]);
        xrnd[j][k] = (xmag[j][k] + HALF) >> sfn_pkg::IFRAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_valid <= 1'b0;
    end else if (en) begin
      x1_valid <= x0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_ctr <= x0_ctr;
      for (int j = 0; j < NB; j++) begin
        for (int k = 0; k < 3; k++) begin
          x1_vec[j][k] <= xdif[j][k][DFW-1] ? -$signed(CW'(xrnd[j][k]))
                                             : $signed(CW'(xrnd[j][k]));
        end
      end
    end
  end

  // Unit cross products.
  logic                   u2_valid;
  logic signed [UW-1:0]   u2_vec [NB][3];
  logic [CP-1:0]          u2_ctr;

  sfn_unit #(
    .LANES(NB), .VW(CW), .SHIFT(sfn_pkg::IFRAC), .PW(CP)
  ) u_cross_unit (
    .clk(clk), .rst(rst), .en(en),
    .src_valid(x1_valid), .src_vec(x1_vec), .src_tag(x1_ctr),
    .res_valid(u2_valid), .res_vec(u2_vec), .res_tag(u2_ctr)
  );

  // Facing test: products of each unit cross product with the centre.
  logic                   f0_valid;
  logic signed [DOTW-1:0] f0_prod [NB][3];
  logic signed [UW-1:0]   f0_vec  [NB][3];
  logic signed [DOTW-1:0] fu [NB][3];
  logic signed [DOTW-1:0] fc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fc[k] = $signed(u2_ctr[k*CB +: CB]);
      for (int j = 0; j < NB; j++) begin
        fu[j][k] = u2_vec[j][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
    end else if (en) begin
      f0_valid <= u2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_vec <= u2_vec;
      for (int j = 0; j < NB; j++) begin
        for (int k = 0; k < 3; k++) begin
          f0_prod[j][k] <= fu[j][k] * fc[k];
        end
      end
    end
  end

  logic                   f1_valid;
  logic                   f1_flip [NB];
  logic signed [UW-1:0]   f1_vec  [NB][3];
  logic signed [DSW-1:0]  fdot    [NB];

  // A product is turned round only when it points away from the sensor,
  // that is when its dot product with the centre is strictly positive.
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      fdot[j] = DSW'(f0_prod[j][0]) + DSW'(f0_prod[j][1]) + DSW'(f0_prod[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= f0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_vec <= f0_vec;
      for (int j = 0; j < NB; j++) begin
        f1_flip[j] <= (fdot[j] > 0);
      end
    end
  end

  // Sum of the four oriented products.
  logic                   s0_valid;
  logic signed [SUMW-1:0] s0_vec [1][3];
  logic signed [SUMW-1:0] sacc [3];
  logic signed [SUMW-1:0] sterm;
  logic [0:0]             s0_nz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sacc[k] = '0;
      for (int j = 0; j < NB; j++) begin
        sterm   = f1_vec[j][k];
        sacc[k] = sacc[k] + (f1_flip[j] ? -sterm : sterm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s0_vec[0][k] <= sacc[k];
      end
    end
  end

  // The result is defined exactly when the summed vector is not all zero.
  assign s0_nz = (s0_vec[0][0] != '0) || (s0_vec[0][1] != '0) || (s0_vec[0][2] != '0);

  logic                   u3_valid;
  logic signed [FW-1:0]   u3_vec [1][3];
  logic [0:0]             u3_nz;

  sfn_unit #(
    .LANES(1), .VW(SUMW), .SHIFT(NORMAL_FRAC_BITS), .PW(1)
  ) u_sum_unit (
    .clk(clk), .rst(rst), .en(en),
    .src_valid(s0_valid), .src_vec(s0_vec), .src_tag(s0_nz),
    .res_valid(u3_valid), .res_vec(u3_vec), .res_tag(u3_nz)
  );

  // Output register with saturation to the unit range.
  logic signed [FW-1:0] sat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      priority if (u3_vec[0][k] > LIM) begin
        sat[k] = LIM;
      end else if (u3_vec[0][k] < -LIM) begin
        sat[k] = -LIM;
      end else begin
        sat[k] = u3_vec[0][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= u3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_x     <= sfn_pkg::OUT_BITS'(sat[0]);
      normal_y     <= sfn_pkg::OUT_BITS'(sat[1]);
      normal_z     <= sfn_pkg::OUT_BITS'(sat[2]);
      normal_valid <= u3_nz[0];
    end
  end

endmodule
